@@ rtl/core/rtsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsp_pkg
// Types and constants shared by the timestamp parser front end and back end.
// ----------------------------------------------------------------------------
package rtsp_pkg;

  typedef enum logic [4:0] {
    PH_FIXED     = 5'b00001,
    PH_AFTER_SEC = 5'b00010,
    PH_FRAC      = 5'b00100,
    PH_OFFSET    = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parsed timestamp, handed from front end to back end
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] fraction;
    logic [3:0]  frac_cnt;
    logic        tz_neg;
    logic [6:0]  tz_hour;
    logic [6:0]  tz_min;
  } req_t;

endpackage

@@ rtl/core/rtsp_front.sv @@
// ----------------------------------------------------------------------------
// rtsp_front
// Character parser: one byte per cycle while acc is high, emits a parsed request on last.
// ----------------------------------------------------------------------------
module rtsp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    character,
  input  logic          last,
  output logic          req_push,
  output rtsp_pkg::req_t req
);
  import rtsp_pkg::*;

  logic [5:0]  pos_r,   pos_nxt;
  phase_t      ph_r,    ph_nxt;
  logic [13:0] year_r,  year_nxt;
  logic [6:0]  mon_r,   mon_nxt;
  logic [6:0]  day_r,   day_nxt;
  logic [6:0]  hour_r,  hour_nxt;
  logic [6:0]  min_r,   min_nxt;
  logic [6:0]  sec_r,   sec_nxt;
  logic [29:0] frac_r,  frac_nxt;
  logic [3:0]  fcnt_r,  fcnt_nxt;
  logic        neg_r,   neg_nxt;
  logic [6:0]  oh_r,    oh_nxt;
  logic [6:0]  om_r,    om_nxt;
  logic [2:0]  k_r,     k_nxt;
  logic        fail_r,  fail_nxt;
  logic        dig;
  logic [3:0]  dval;
  logic        ok;

  assign dig  = (character >= CH_ZERO) && (character <= CH_NINE);
  assign dval = 4'(character - CH_ZERO);

  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    acc7 = 7'(v * 7'd10 + 7'(d));
  endfunction

  always_comb begin
    pos_nxt  = pos_r;  ph_nxt  = ph_r;   year_nxt = year_r; mon_nxt = mon_r;
    day_nxt  = day_r;  hour_nxt = hour_r; min_nxt = min_r;  sec_nxt = sec_r;
    frac_nxt = frac_r; fcnt_nxt = fcnt_r; neg_nxt = neg_r;  oh_nxt  = oh_r;
    om_nxt   = om_r;   k_nxt   = k_r;    fail_nxt = fail_r;
    if (!fail_r) begin
      unique case (ph_r)
        PH_FIXED: begin
          if (pos_r == 6'd4 || pos_r == 6'd7) begin
            if (character != CH_DASH) fail_nxt = 1'b1;
          end else if (pos_r == 6'd10) begin
            if (character != CH_T_UP && character != CH_T_LO) fail_nxt = 1'b1;
          end else if (pos_r == 6'd13 || pos_r == 6'd16) begin
            if (character != CH_COLON) fail_nxt = 1'b1;
          end else if (!dig) begin
            fail_nxt = 1'b1;
          end else if (pos_r < 6'd4) begin
            year_nxt = 14'(year_r * 14'd10 + 14'(dval));
          end else if (pos_r < 6'd7) begin
            mon_nxt = acc7(mon_r, dval);
          end else if (pos_r < 6'd10) begin
            day_nxt = acc7(day_r, dval);
          end else if (pos_r < 6'd13) begin
            hour_nxt = acc7(hour_r, dval);
          end else if (pos_r < 6'd16) begin
            min_nxt = acc7(min_r, dval);
          end else begin
            sec_nxt = acc7(sec_r, dval);
          end
          if (pos_r == 6'd18) ph_nxt = PH_AFTER_SEC;
        end
        PH_AFTER_SEC, PH_FRAC: begin
          if (ph_r == PH_AFTER_SEC && character == CH_DOT) begin
            ph_nxt = PH_FRAC;
          end else if (ph_r == PH_FRAC && dig) begin
            if (fcnt_r >= 4'd9) fail_nxt = 1'b1;
            else begin
              frac_nxt = 30'(frac_r * 30'd10 + 30'(dval));
              fcnt_nxt = fcnt_r + 4'd1;
            end
          end else if (ph_r == PH_FRAC && fcnt_r == 4'd0) begin
            fail_nxt = 1'b1;
          end else if (character == CH_Z_UP || character == CH_Z_LO) begin
            ph_nxt = PH_DONE;
          end else if (character == CH_PLUS || character == CH_DASH) begin
            ph_nxt  = PH_OFFSET;
            neg_nxt = (character == CH_DASH);
            k_nxt   = 3'd0;
          end else begin
            fail_nxt = 1'b1;
          end
        end
        PH_OFFSET: begin
          if (k_r == 3'd2) begin
            if (character != CH_COLON) fail_nxt = 1'b1;
          end else if (!dig) begin
            fail_nxt = 1'b1;
          end else if (k_r < 3'd2) begin
            oh_nxt = acc7(oh_r, dval);
          end else begin
            om_nxt = acc7(om_r, dval);
          end
          if (k_r >= 3'd4) ph_nxt = PH_DONE;
          k_nxt = k_r + 3'd1;
        end
        default: fail_nxt = 1'b1;
      endcase
    end
    if (pos_r != 6'd63) pos_nxt = pos_r + 6'd1;
  end

  assign ok = !fail_nxt && ph_nxt == PH_DONE && mon_nxt >= 7'd1 && mon_nxt <= 7'd12 &&
              day_nxt >= 7'd1 && day_nxt <= 7'd31 && hour_nxt <= 7'd23 &&
              min_nxt <= 7'd59 && sec_nxt <= 7'd60;

  assign req_push = acc && last;
  always_comb begin
    req.ok       = ok;
    req.year     = year_nxt;
    req.month    = mon_nxt[3:0];
    req.day      = day_nxt[4:0];
    req.hour     = hour_nxt[4:0];
    req.minute   = min_nxt[5:0];
    req.second   = sec_nxt[5:0];
    req.fraction = frac_nxt;
    req.frac_cnt = fcnt_nxt;
    req.tz_neg   = neg_nxt;
    req.tz_hour  = oh_nxt;
    req.tz_min   = om_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      pos_r <= '0; ph_r <= PH_FIXED; year_r <= '0; mon_r <= '0; day_r <= '0;
      hour_r <= '0; min_r <= '0; sec_r <= '0; frac_r <= '0; fcnt_r <= '0;
      neg_r <= 1'b0; oh_r <= '0; om_r <= '0; k_r <= '0; fail_r <= 1'b0;
    end else if (acc) begin
      pos_r <= pos_nxt; ph_r <= ph_nxt; year_r <= year_nxt; mon_r <= mon_nxt;
      day_r <= day_nxt; hour_r <= hour_nxt; min_r <= min_nxt; sec_r <= sec_nxt;
      frac_r <= frac_nxt; fcnt_r <= fcnt_nxt; neg_r <= neg_nxt; oh_r <= oh_nxt;
      om_r <= om_nxt; k_r <= k_nxt; fail_r <= fail_nxt;
    end
  end

endmodule

@@ rtl/core/rtsp_fifo.sv @@
// ----------------------------------------------------------------------------
// rtsp_fifo
// Two-entry request queue between front end and back end.
// ----------------------------------------------------------------------------
module rtsp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtsp_pkg::req_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rtsp_pkg::req_t rdata
);
  import rtsp_pkg::*;

  req_t       mem [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];
  assign wp_nxt  = wp_r ^ do_push;
  assign rp_nxt  = rp_r ^ do_pop;
  assign cnt_nxt = 2'(cnt_r + {1'b0, do_push} - {1'b0, do_pop});

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/rtsp_back.sv @@
// ----------------------------------------------------------------------------
// rtsp_back
// Five-stage epoch pipeline: days-from-civil, time of day, zone, nanoseconds.
// ----------------------------------------------------------------------------
module rtsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  rtsp_pkg::req_t      req,
  output logic                req_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_ok,
  output logic signed [38:0]  out_epoch_seconds,
  output logic [29:0]         out_nanoseconds
);
  import rtsp_pkg::*;

  function automatic logic [8:0] month_days(input logic [3:0] m);
    case (m)
      4'd3:    month_days = 9'd0;
      4'd4:    month_days = 9'd31;
      4'd5:    month_days = 9'd61;
      4'd6:    month_days = 9'd92;
      4'd7:    month_days = 9'd122;
      4'd8:    month_days = 9'd153;
      4'd9:    month_days = 9'd184;
      4'd10:   month_days = 9'd214;
      4'd11:   month_days = 9'd245;
      4'd12:   month_days = 9'd275;
      4'd1:    month_days = 9'd306;
      4'd2:    month_days = 9'd337;
      default: month_days = 9'd0;
    endcase
  endfunction

  function automatic logic [29:0] pow10(input logic [3:0] n);
    case (n)
      4'd0:    pow10 = 30'd1000000000;
      4'd1:    pow10 = 30'd100000000;
      4'd2:    pow10 = 30'd10000000;
      4'd3:    pow10 = 30'd1000000;
      4'd4:    pow10 = 30'd100000;
      4'd5:    pow10 = 30'd10000;
      4'd6:    pow10 = 30'd1000;
      4'd7:    pow10 = 30'd100;
      4'd8:    pow10 = 30'd10;
      default: pow10 = 30'd1;
    endcase
  endfunction

  logic en;
  logic va_r, vb_r, vc_r, vd_r, ve_r;

  // stage A
  logic signed [14:0] y;
  logic [9:0]         yq;
  logic [20:0]        yprod;
  logic signed [5:0]  era;
  logic signed [14:0] a_y_r;
  logic signed [5:0]  a_era_r;
  logic [8:0]         a_doy_r;
  logic [16:0]        a_tod_r;
  logic [18:0]        a_tz_r;
  logic               a_neg_r, a_ok_r;
  logic [29:0]        a_ns_r;
  logic [59:0]        ns_full;
  // stage B
  logic signed [5:0]  b_era_r;
  logic [8:0]         b_yoe_r, b_doy_r;
  logic signed [19:0] b_secd_r;
  logic [29:0]        b_ns_r;
  logic               b_ok_r;
  logic signed [14:0] yoe_s;
  // stage C
  logic [6:0]         yoe4;
  logic [17:0]        cprod;
  logic signed [5:0]  c_era_r;
  logic [17:0]        c_doe_r;
  logic signed [19:0] c_secd_r;
  logic [29:0]        c_ns_r;
  logic               c_ok_r;
  // stage D
  logic signed [23:0] d_days_r;
  logic signed [19:0] d_secd_r;
  logic [29:0]        d_ns_r;
  logic               d_ok_r;
  // stage E
  logic signed [38:0] secs;

  assign en        = !ve_r || out_pop;
  assign req_pop   = en && req_valid;
  assign out_empty = !ve_r;

  assign y       = $signed({1'b0, req.year}) - ((req.month <= 4'd2) ? 15'sd1 : 15'sd0);
  assign yq      = 10'(y[13:4]);
  assign yprod   = 21'(yq) * 21'd1311;
  assign era     = y[14] ? -6'sd1 : $signed({1'b0, yprod[19:15]});
  assign ns_full = 60'(req.fraction) * 60'(pow10(req.frac_cnt));
  assign yoe_s   = a_y_r - 15'(a_era_r * 15'sd400);
  assign yoe4    = 7'(b_yoe_r[8:2]);
  assign cprod   = 18'(yoe4) * 18'd1311;
  assign secs    = 39'(d_days_r) * 39'sd86400 + 39'(d_secd_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_y_r   <= y;
      a_era_r <= era;
      a_doy_r <= 9'(month_days(req.month) + 9'(req.day) - 9'd1);
      a_tod_r <= 17'(req.hour * 17'd3600 + req.minute * 17'd60 + 17'(req.second));
      a_tz_r  <= 19'(req.tz_hour * 19'd3600 + req.tz_min * 19'd60);
      a_neg_r <= req.tz_neg;
      a_ns_r  <= ns_full[29:0];
      a_ok_r  <= req.ok;

      b_era_r  <= a_era_r;
      b_yoe_r  <= yoe_s[8:0];
      b_doy_r  <= a_doy_r;
      b_secd_r <= a_neg_r ? $signed(20'(a_tod_r) + 20'(a_tz_r))
                          : $signed(20'(a_tod_r) - 20'(a_tz_r));
      b_ns_r   <= a_ns_r;
      b_ok_r   <= a_ok_r;

      c_era_r  <= b_era_r;
      c_doe_r  <= 18'(b_yoe_r) * 18'd365 + 18'(yoe4) - 18'(cprod[17:15])
                  + 18'(b_doy_r);
      c_secd_r <= b_secd_r;
      c_ns_r   <= b_ns_r;
      c_ok_r   <= b_ok_r;

      d_days_r <= 24'(c_era_r) * 24'sd146097 + $signed({6'd0, c_doe_r}) - 24'sd719468;
      d_secd_r <= c_secd_r;
      d_ns_r   <= c_ns_r;
      d_ok_r   <= c_ok_r;

      out_ok            <= d_ok_r;
      out_epoch_seconds <= d_ok_r ? secs : '0;
      out_nanoseconds   <= d_ok_r ? d_ns_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0; ve_r <= 1'b0;
    end else if (en) begin
      va_r <= req_valid; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r; ve_r <= vd_r;
    end
  end

endmodule

@@ rtl/core/rfc3339_timestamp_parser_unit.sv @@
// ----------------------------------------------------------------------------
// rfc3339_timestamp_parser_unit
// Streaming RFC 3339 timestamp to Unix seconds and nanoseconds.
// ----------------------------------------------------------------------------
// Input: one character per push, in_last on the final one. A character is
// taken when in_push is high and in_full low; one character per cycle.
// Every string yields exactly one result at its last character: out_ok,
// out_epoch_seconds and out_nanoseconds (zero fields when out_ok is low).
// Results are read like a queue: valid while out_empty is low, taken by
// out_pop. The front end parses a character per cycle and queues the parsed
// request in a two-entry queue; the back end is a five-stage pipeline that
// takes a new request while earlier ones are still in flight.
// When the result side stalls, the pipeline holds, the queue fills and
// in_full rises; in_full is then high until results are popped.
// Synchronous reset clears the parser, the queue and the result valid flags.
// ----------------------------------------------------------------------------
module rfc3339_timestamp_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_character,
  input  logic               in_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_ok,
  output logic signed [38:0] out_epoch_seconds,
  output logic [29:0]        out_nanoseconds
);
  import rtsp_pkg::*;

  logic q_full, q_empty, q_push, q_pop, acc;
  req_t f_req, b_req;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  rtsp_front u_front (
    .clk, .rst_n, .acc, .character(in_character), .last(in_last),
    .req_push(q_push), .req(f_req)
  );

  rtsp_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(f_req), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(b_req)
  );

  rtsp_back u_back (
    .clk, .rst_n, .req_valid(!q_empty), .req(b_req), .req_pop(q_pop),
    .out_empty, .out_pop, .out_ok, .out_epoch_seconds, .out_nanoseconds
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams timestamp text through the parser one character per request and
// checks every result field against an in-bench parser model. Directed
// strings cover the field extremes and each malformed form. Random strings
// follow, mostly well-formed with random content and some broken or noise
// strings. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module testbench;
  import rtsp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct {
    bit              ok;
    logic [38:0]     secs;
    logic [29:0]     nanos;
  } stamp_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_character;
  logic               in_last;
  logic               out_empty;
  logic               out_pop;
  logic               out_ok;
  logic signed [38:0] out_epoch_seconds;
  logic [29:0]        out_nanoseconds;

  char_req_t pending_chars[$];
  stamp_t    expected_stamps[$];
  int        send_idle;
  int        recv_idle;
  int        error_count;
  int        quiet_cycles;

  // parser model state
  int     pos;
  phase_t phase;
  int     yr, mon, dy, hr, mnt, sec;
  int     frac, frac_cnt;
  bit     tz_neg;
  int     tz_hr, tz_mn;
  bit     bad;

  rfc3339_timestamp_parser_unit dut (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parser();
    pos = 0;
    phase = PH_FIXED;
    {yr, mon, dy, hr, mnt, sec, frac, frac_cnt, tz_hr, tz_mn} = '0;
    tz_neg = 0;
    bad = 0;
  endtask

  task automatic zone_begin(logic [7:0] c);
    if (c == CH_Z_UP || c == CH_Z_LO) begin
      phase = PH_DONE;
    end else if (c == CH_PLUS || c == CH_DASH) begin
      phase = PH_OFFSET;
      tz_neg = (c == CH_DASH);
    end else begin
      bad = 1;
    end
  endtask

  task automatic parse_char(logic [7:0] c, bit last);
    int     d;
    int     k;
    longint y, era, yoe, doy, doe, days, tz, secs;
    int     m;
    stamp_t r;
    d = int'(c) - 48;
    if (!bad) begin
      case (phase)
        PH_FIXED: begin
          if (pos == 4 || pos == 7) begin
            if (c != CH_DASH) bad = 1;
          end else if (pos == 10) begin
            if (c != CH_T_UP && c != CH_T_LO) bad = 1;
          end else if (pos == 13 || pos == 16) begin
            if (c != CH_COLON) bad = 1;
          end else if (!is_num(c)) begin
            bad = 1;
          end else if (pos < 4) begin
            yr = yr * 10 + d;
          end else if (pos < 7) begin
            mon = mon * 10 + d;
          end else if (pos < 10) begin
            dy = dy * 10 + d;
          end else if (pos < 13) begin
            hr = hr * 10 + d;
          end else if (pos < 16) begin
            mnt = mnt * 10 + d;
          end else begin
            sec = sec * 10 + d;
          end
          if (pos == 18) phase = PH_AFTER_SEC;
        end
        PH_AFTER_SEC: begin
          if (c == CH_DOT) phase = PH_FRAC;
          else zone_begin(c);
        end
        PH_FRAC: begin
          if (is_num(c)) begin
            if (frac_cnt >= 9) bad = 1;
            else begin
              frac = frac * 10 + d;
              frac_cnt++;
            end
          end else if (frac_cnt == 0) begin
            bad = 1;
          end else begin
            zone_begin(c);
          end
        end
        PH_OFFSET: begin
          k = pos - ((frac_cnt == 0) ? 19 : 20 + frac_cnt) - 1;
          if (k == 2) begin
            if (c != CH_COLON) bad = 1;
          end else if (!is_num(c)) begin
            bad = 1;
          end else if (k < 2) begin
            tz_hr = (tz_hr * 10 + d) & 8'h7F;
          end else begin
            tz_mn = (tz_mn * 10 + d) & 8'h7F;
          end
          if (k >= 4) phase = PH_DONE;
        end
        default: bad = 1;
      endcase
    end
    if (pos < 63) pos++;
    if (!last) return;
    r.ok = !bad && phase == PH_DONE && mon >= 1 && mon <= 12 && dy >= 1 && dy <= 31 &&
           hr <= 23 && mnt <= 59 && sec <= 60;
    r.secs = '0;
    r.nanos = '0;
    if (r.ok) begin
      m = mon;
      y = yr - ((m <= 2) ? 1 : 0);
      era = ((y >= 0) ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      tz = longint'(tz_hr) * 3600 + longint'(tz_mn) * 60;
      if (tz_neg) tz = -tz;
      secs = days * 86400 + longint'(hr) * 3600 + longint'(mnt) * 60 + sec - tz;
      r.secs = secs[38:0];
      r.nanos = frac;
      for (int i = frac_cnt; i < 9; i++) r.nanos = r.nanos * 10;
    end
    expected_stamps.push_back(r);
    clear_parser();
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_bytes(byte unsigned b[$]);
    foreach (b[i]) pending_chars.push_back('{ch: b[i], last: (i == b.size() - 1)});
  endtask

  task automatic queue_text(string s);
    byte unsigned b[$];
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    queue_bytes(b);
  endtask

  // Random timestamp, mostly well-formed, sometimes out of range or broken
  task automatic queue_random_stamp();
    string        s;
    string        z;
    byte unsigned b[$];
    int           n;
    int           mode;
    bit           wide;
    wide = ($urandom_range(9) == 0);
    s = $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", $urandom_range(9999),
                  wide ? $urandom_range(99) : $urandom_range(12, 1),
                  wide ? $urandom_range(99) : $urandom_range(31, 1),
                  $urandom_range(1) ? "T" : "t",
                  wide ? $urandom_range(99) : $urandom_range(23),
                  wide ? $urandom_range(99) : $urandom_range(59),
                  wide ? $urandom_range(99) : $urandom_range(60));
    n = $urandom_range(3) == 0 ? 0 : $urandom_range(($urandom_range(15) == 0) ? 10 : 9, 1);
    if (n > 0) begin
      s = {s, "."};
      for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    case ($urandom_range(3))
      0: z = "Z";
      1: z = "z";
      default: z = $sformatf("%s%02d:%02d", $urandom_range(1) ? "+" : "-",
                             $urandom_range(99), $urandom_range(99));
    endcase
    s = {s, z};
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    mode = $urandom_range(9);
    if (mode == 0) b[$urandom_range(b.size() - 1)] = $urandom_range(255);
    else if (mode == 1) b = b[0:$urandom_range(b.size() - 2)];
    else if (mode == 2) b.push_back($urandom_range(255));
    queue_bytes(b);
  endtask

  task automatic queue_noise();
    byte unsigned b[$];
    int           n;
    n = $urandom_range(3) == 0 ? $urandom_range(70, 40) : $urandom_range(30, 1);
    for (int i = 0; i < n; i++) b.push_back($urandom_range(255));
    queue_bytes(b);
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || in_push || expected_stamps.size() != 0)
      @(posedge clk);
  endtask

  // request side
  always @(posedge clk) begin
    char_req_t nxt;
    bit        go;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_character <= '0;
      in_last <= 1'b0;
    end else begin
      go = in_push;
      if (in_push && !in_full) begin
        parse_char(in_character, in_last);
        go = 1'b0;
      end
      if (!go) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = pending_chars.pop_front();
          in_character <= nxt.ch;
          in_last <= nxt.last;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    stamp_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if ((out_pop && !out_empty) || (in_push && !in_full)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_pop && !out_empty) begin
        if (expected_stamps.size() == 0) begin
          report("unexpected result", out_ok, 0);
        end else begin
          e = expected_stamps.pop_front();
          if (out_ok !== e.ok) report("ok", out_ok, e.ok);
          if (out_epoch_seconds !== $signed(e.secs))
            report("epoch_seconds", out_epoch_seconds, $signed(e.secs));
          if (out_nanoseconds !== e.nanos) report("nanoseconds", out_nanoseconds, e.nanos);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle);
      if (quiet_cycles > 5000) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_character = '0;
    in_last = 1'b0;
    out_pop = 1'b0;
    send_idle = 23;
    recv_idle = 77;
    error_count = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_text("0000-01-01T00:00:00Z");
    queue_text("9999-12-31t23:59:60.999999999z");
    queue_text("1970-01-01T00:00:00.1+99:99");
    queue_text("2000-02-29T12:30:45.000000001-99:99");
    queue_text("1969-12-31T23:59:59.5-00:30");
    queue_text("2021-00-10T00:00:00Z");
    queue_text("2021-13-10T00:00:00Z");
    queue_text("2021-02-00T00:00:00Z");
    queue_text("2021-02-32T00:00:00Z");
    queue_text("2021-02-31T24:00:00Z");
    queue_text("2021-02-01T23:60:00Z");
    queue_text("2021-02-01T23:59:61Z");
    queue_text("2021-02-01T23:59:59.1234567890Z");
    queue_text("2021-02-01T23:59:59.Z");
    queue_text("2021-02-01T23:59:59ZZ");
    queue_text("2021-02-01T23:59:59+05:3");
    queue_text("2021-02-01 23:59:59Z");
    queue_text("2021/02/01T23:59:59Z");
    queue_text("2021-02-01T23-59:59Z");
    queue_text("2021-02-01T23:59:59+05-30");
    queue_text("Z");
    queue_text("2021-02-01T23:59:59.5");
    queue_text("2021-02-01T23:59:59.5x");
    queue_text("0000-01-01T00:00:00Z0000000000000000000000000000000000000000000000000");
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 77 : 0;
      recv_idle = (ph == 0) ? 77 : (ph == 1) ? 23 : 0;
      sent = 0;
      while (sent < 225) begin
        sent -= pending_chars.size();
        if ($urandom_range(7) == 0) queue_noise();
        else queue_random_stamp();
        sent += pending_chars.size();
      end
      drain();
    end
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
